[rtl/core/sfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int DEF_MAX_PATTERN_LEN     = 8;
    localparam int DEF_MAX_REPLACEMENT_LEN = 8;

    // most result bytes one request can produce
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES     = 3'd0,
        REG_PATTERN_LEN       = 3'd1,
        REG_REPLACEMENT_BYTES = 3'd2,
        REG_REPLACEMENT_LEN   = 3'd3,
        REG_LIMIT_ENABLED     = 3'd4,
        REG_REPLACE_LIMIT     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_len;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_len;
        logic        limit_enabled;
        logic [31:0] replace_limit;
    } cfg_t;

    // bytes released by one request, first byte in slot 0
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [MAX_OUT-1:0]      from_rep;
        logic [CNT_W-1:0]        cnt;
        logic                    eos;
    } emit_t;

endpackage : sfr_pkg
`default_nettype wire

[rtl/core/sfr_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_step
// Combinational next-state and byte release for one source byte.
// ----------------------------------------------------------------------------
module sfr_step #(
    parameter int P = sfr_pkg::DEF_MAX_PATTERN_LEN,
    parameter int R = sfr_pkg::DEF_MAX_REPLACEMENT_LEN
) (
    input  logic [P-1:0][7:0]           win_i,
    input  logic [$clog2(P+1)-1:0]      fill_i,
    input  logic [7:0]                  byte_i,
    input  logic                        eos_i,
    input  sfr_pkg::cfg_t               cfg_i,
    input  logic [31:0]                 done_i,
    output sfr_pkg::emit_t              emit_o,
    output logic [P-1:0][7:0]           win_o,
    output logic [$clog2(P+1)-1:0]      fill_o,
    output logic [31:0]                 done_o
);
    import sfr_pkg::*;

    localparam int FILL_W = $clog2(P + 1);

    logic [P-1:0][7:0]  w;
    logic [P-1:0]       ok;
    logic [CNT_W-1:0]   plen;
    logic [CNT_W-1:0]   rlen;
    logic [CNT_W-1:0]   n;
    logic [CNT_W-1:0]   ksel;
    logic [CNT_W-1:0]   run_len;
    logic [CNT_W-1:0]   src_cnt;
    logic [CNT_W-1:0]   rep_cnt;
    logic [CNT_W:0]     total;
    logic [2:0]         ridx;
    logic               limited;
    logic               match;

    always_comb begin
        // effective lengths
        plen = cfg_i.pattern_len;
        if (plen == '0) plen = CNT_W'(1);
        if (plen > CNT_W'(P)) plen = CNT_W'(P);
        rlen = cfg_i.replacement_len;
        if (rlen > CNT_W'(R)) rlen = CNT_W'(R);

        limited = cfg_i.limit_enabled && (done_i >= cfg_i.replace_limit);

        // window with the new byte appended
        n = CNT_W'(fill_i) + CNT_W'(1);
        for (int i = 0; i < P; i++) begin
            if (CNT_W'(i) < CNT_W'(fill_i)) begin
                w[i] = win_i[i];
            end else if (CNT_W'(i) == CNT_W'(fill_i)) begin
                w[i] = byte_i;
            end else begin
                w[i] = 8'h00;
            end
        end

        // ok[k]: bytes from k to the end still prefix the pattern
        for (int k = 0; k < P; k++) begin
            ok[k] = (CNT_W'(k) < n) && ((n - CNT_W'(k)) <= plen);
            for (int i = 0; i < P; i++) begin
                if ((k + i < P) && (CNT_W'(k + i) < n) &&
                    (w[(k+i) % P] != cfg_i.pattern_bytes[8*i +: 8])) begin
                    ok[k] = 1'b0;
                end
            end
        end

        // smallest start that survives; limit reached releases all
        ksel = n;
        if (!limited) begin
            for (int k = P - 1; k >= 0; k--) begin
                if (ok[k]) ksel = CNT_W'(k);
            end
        end

        run_len = n - ksel;
        match   = !limited && (run_len == plen);
        src_cnt = (eos_i && !match) ? n : ksel;
        rep_cnt = match ? rlen : '0;
        total   = {1'b0, src_cnt} + {1'b0, rep_cnt};

        emit_o.eos = eos_i;
        emit_o.cnt = (total > (CNT_W+1)'(MAX_OUT)) ? CNT_W'(MAX_OUT) : total[CNT_W-1:0];
        for (int j = 0; j < MAX_OUT; j++) begin
            ridx = 3'(CNT_W'(j) - src_cnt);
            if (CNT_W'(j) < src_cnt) begin
                emit_o.data[j]     = (j < P) ? w[j % P] : 8'h00;
                emit_o.from_rep[j] = 1'b0;
            end else begin
                emit_o.data[j]     = cfg_i.replacement_bytes[{ridx, 3'b000} +: 8];
                emit_o.from_rep[j] = 1'b1;
            end
        end

        // shift out released bytes
        for (int i = 0; i < P; i++) begin
            win_o[i] = 8'h00;
            for (int k = 0; k < P; k++) begin
                if ((k + i < P) && (ksel == CNT_W'(k))) win_o[i] = w[(k+i) % P];
            end
        end

        fill_o = (match || eos_i) ? '0 : FILL_W'(run_len);

        if (eos_i) begin
            done_o = '0;
        end else if (match && !(&done_i)) begin
            done_o = done_i + 32'd1;
        end else begin
            done_o = done_i;
        end
    end

endmodule : sfr_step
`default_nettype wire

[rtl/core/sfr_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_out_buf
// Result register: holds the bytes of one request and drains one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module sfr_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load_i,
    input  sfr_pkg::emit_t  emit_i,
    output logic            ready_o,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // string_last
    output logic [1:0]      m_tuser    // [0] run_last, [1] from_replacement
);
    import sfr_pkg::*;

    logic [MAX_OUT-1:0][7:0] data_reg, data_next;
    logic [MAX_OUT-1:0]      rep_reg, rep_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    eos_reg, eos_next;
    logic                    pop;
    logic                    last;

    assign pop     = m_tvalid && m_tready;
    assign last    = (cnt_reg == CNT_W'(1));
    assign ready_o = (cnt_reg == '0) || (last && m_tready);

    assign m_tvalid   = (cnt_reg != '0);
    assign m_tdata    = data_reg[0];
    assign m_tlast    = last && eos_reg;
    assign m_tuser[0] = last;
    assign m_tuser[1] = rep_reg[0];

    always_comb begin
        data_next = data_reg;
        rep_next  = rep_reg;
        cnt_next  = cnt_reg;
        eos_next  = eos_reg;
        if (load_i) begin
            data_next = emit_i.data;
            rep_next  = emit_i.from_rep;
            cnt_next  = emit_i.cnt;
            eos_next  = emit_i.eos;
        end else if (pop) begin
            for (int j = 0; j < MAX_OUT - 1; j++) begin
                data_next[j] = data_reg[j+1];
                rep_next[j]  = rep_reg[j+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            eos_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            eos_reg <= eos_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rep_reg  <= rep_next;
    end

endmodule : sfr_out_buf
`default_nettype wire

[rtl/core/stream_find_and_replace.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte-stream find and replace: pattern of 1..8 bytes, replacement 0..8.
// ----------------------------------------------------------------------------
// Output: the first result byte of a request is on m_* in the cycle after accept.
// Input: one request per cycle while each releases at most one byte and m_tready
//   is high; a request releasing more holds the input until its last byte is
//   taken, the result register draining one byte per cycle while m_tready is high.
// Reset: synchronous, active low; clears config to defaults, window fill,
//   replacement count and the result register. No clearing pass.
// ----------------------------------------------------------------------------
module stream_find_and_replace #(
    parameter int MAX_PATTERN_LEN     = sfr_pkg::DEF_MAX_PATTERN_LEN,
    parameter int MAX_REPLACEMENT_LEN = sfr_pkg::DEF_MAX_REPLACEMENT_LEN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // source bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // in_byte
    input  logic                            s_tlast,   // end_of_string
    // rewritten bytes
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic                            m_tlast,   // string_last
    output logic [1:0]                      m_tuser    // [0] run_last, [1] from_replacement
);
    import sfr_pkg::*;

    localparam int P      = MAX_PATTERN_LEN;
    localparam int FILL_W = $clog2(P + 1);

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_bytes     <= '0;
            cfg_reg.pattern_len       <= 4'd1;
            cfg_reg.replacement_bytes <= '0;
            cfg_reg.replacement_len   <= '0;
            cfg_reg.limit_enabled     <= 1'b0;
            cfg_reg.replace_limit     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:     cfg_reg.pattern_bytes     <= cfg_wdata;
                REG_PATTERN_LEN:       cfg_reg.pattern_len       <= cfg_wdata[3:0];
                REG_REPLACEMENT_BYTES: cfg_reg.replacement_bytes <= cfg_wdata;
                REG_REPLACEMENT_LEN:   cfg_reg.replacement_len   <= cfg_wdata[3:0];
                REG_LIMIT_ENABLED:     cfg_reg.limit_enabled     <= cfg_wdata[0];
                REG_REPLACE_LIMIT:     cfg_reg.replace_limit     <= cfg_wdata[31:0];
                default: ;  // index beyond the list: ignored
            endcase
        end
    end

    // match window: bytes that still prefix the pattern
    logic [P-1:0][7:0]   win_reg, win_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [31:0]         done_reg, done_next;
    emit_t               emit;
    logic                accept;

    assign accept = s_tvalid && s_tready;

    sfr_step #(
        .P (MAX_PATTERN_LEN),
        .R (MAX_REPLACEMENT_LEN)
    ) u_step (
        .win_i  (win_reg),
        .fill_i (fill_reg),
        .byte_i (s_tdata),
        .eos_i  (s_tlast),
        .cfg_i  (cfg_reg),
        .done_i (done_reg),
        .emit_o (emit),
        .win_o  (win_next),
        .fill_o (fill_next),
        .done_o (done_next)
    );

    // window state advances only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            done_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

    // bytes past the fill are never read
    always_ff @(posedge aclk) begin
        if (accept) win_reg <= win_next;
    end

    // result register; input is ready whenever it is empty or empties this cycle
    sfr_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (accept),
        .emit_i   (emit),
        .ready_o  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule : stream_find_and_replace
`default_nettype wire

[rtl/core/sfr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for stream_find_and_replace, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // end of string only on the last byte of a request
    a_last_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("string_last without run_last");

    // no new request while more than one byte of the current one remains
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !s_tready)
        else $error("input ready mid run");

    // a run continues after a byte that is not its last
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid)
        else $error("run ended early");

endmodule : sfr_checker

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);
`default_nettype wire
